// ----- rtl/xsed_pkg.sv -----
`timescale 1ns / 1ps

package xsed_pkg;

   // widths fixed by the item formats
   localparam int OBJECT_W         = 32;
   localparam int COUNT_W          = 32;
   localparam int BYTE_W           = 8;
   localparam int TYPE_W           = 32;
   localparam int VALUE_W          = 64;
   localparam int STATUS_W         = 2;
   localparam int POS_W            = 5;
   localparam int TYPE_WIDTH_W     = 3;
   localparam int FIELD_WIDTH_W    = 4;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 4;

   localparam int MAX_FIELD_BYTES_DEF = 8;
   localparam int TYPE_MAX_BYTES      = 4;
   localparam int GEN_BITS            = 16;

   // request operations
   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_BODY   = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TYPE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SECOND_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_THIRD_WIDTH  = 2'd2;

   // register reset values
   localparam logic [TYPE_WIDTH_W-1:0]  TYPE_WIDTH_RST   = 3'd1;
   localparam logic [FIELD_WIDTH_W-1:0] SECOND_WIDTH_RST = 4'd4;
   localparam logic [FIELD_WIDTH_W-1:0] THIRD_WIDTH_RST  = 4'd2;

   // entry types
   localparam logic [TYPE_W-1:0] TYPE_FREE       = 32'd0;
   localparam logic [TYPE_W-1:0] TYPE_IN_USE     = 32'd1;
   localparam logic [TYPE_W-1:0] TYPE_COMPRESSED = 32'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BIG_GEN   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd3;

   typedef struct packed {
      logic                operation;
      logic [OBJECT_W-1:0] first_object;
      logic [COUNT_W-1:0]  entry_count;
      logic [BYTE_W-1:0]   data_byte;
   } req_type;

   typedef struct packed {
      logic [OBJECT_W-1:0] object_number;
      logic [TYPE_W-1:0]   entry_type;
      logic [VALUE_W-1:0]  second_value;
      logic [VALUE_W-1:0]  third_value;
      logic                last_in_subsection;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

// ----- rtl/xref_stream_entry_decoder.sv -----
`timescale 1ns / 1ps

// Cross-reference stream entry decoder: a header request opens a subsection
// (first object number, entry count), then each body request shifts one byte,
// big-endian, into the type, second or third field, whose byte widths come
// from the three csr registers (write them only while the block is idle).
// When an entry's last byte arrives the decoded entry is registered in the
// response register, or in the skid buffer if that is held; a body byte
// outside any subsection returns a status-3 entry. Throughput is one request
// per cycle while req_stall is low: each byte is decoded by one pass of logic
// between the entry state registers and the response register, which has a
// one-entry skid buffer; req_stall rises only when both are held by rsp_stall.
module xref_stream_entry_decoder #(
   parameter int MAX_FIELD_BYTES = xsed_pkg::MAX_FIELD_BYTES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  xsed_pkg::req_type                     req_data,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output xsed_pkg::rsp_type                     rsp_data,
   // register write port
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [xsed_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [xsed_pkg::CSR_DATA_W-1:0]       csr_data
);
   import xsed_pkg::*;

   // accumulators only need the widest field the parameter allows
   localparam int ACC_W = 8 * MAX_FIELD_BYTES;

   // configuration
   logic [TYPE_WIDTH_W-1:0]  type_width_ff;
   logic [FIELD_WIDTH_W-1:0] second_width_ff;
   logic [FIELD_WIDTH_W-1:0] third_width_ff;

   // entry state
   logic [POS_W-1:0]    byte_position_ff,   byte_position_in;
   logic [TYPE_W-1:0]   type_acc_ff,        type_acc_in;
   logic [ACC_W-1:0]    second_acc_ff,      second_acc_in;
   logic [ACC_W-1:0]    third_acc_ff,       third_acc_in;
   logic [OBJECT_W-1:0] current_object_ff,  current_object_in;
   logic [COUNT_W-1:0]  entries_left_ff,    entries_left_in;

   // output register and skid buffer
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff,  skid_data_in;

   // decode datapath
   logic                     req_accept;
   logic                     rsp_pop;
   logic                     produce;
   rsp_type                  result;
   logic [TYPE_WIDTH_W-1:0]  tw;
   logic [FIELD_WIDTH_W-1:0] sw;
   logic [FIELD_WIDTH_W-1:0] hw;
   logic [POS_W-1:0]         type_end;
   logic [POS_W-1:0]         second_end;
   logic [POS_W-1:0]         total;
   logic [POS_W-1:0]         pos_next;
   logic [TYPE_W-1:0]        type_acc_nx;
   logic [ACC_W-1:0]         second_acc_nx;
   logic [ACC_W-1:0]         third_acc_nx;
   logic                     entry_done;
   logic [TYPE_W-1:0]        etype;
   logic                     gen_big;

   assign req_accept = req_valid && !req_stall;
   assign rsp_pop    = rsp_valid_ff && !rsp_stall;
   assign req_stall  = skid_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // clamp oversized widths
   assign tw = (type_width_ff > TYPE_WIDTH_W'(TYPE_MAX_BYTES)) ?
               TYPE_WIDTH_W'(TYPE_MAX_BYTES) : type_width_ff;
   assign sw = (second_width_ff > FIELD_WIDTH_W'(MAX_FIELD_BYTES)) ?
               FIELD_WIDTH_W'(MAX_FIELD_BYTES) : second_width_ff;
   assign hw = (third_width_ff > FIELD_WIDTH_W'(MAX_FIELD_BYTES)) ?
               FIELD_WIDTH_W'(MAX_FIELD_BYTES) : third_width_ff;

   assign type_end   = POS_W'(tw);
   assign second_end = type_end + POS_W'(sw);
   assign total      = second_end + POS_W'(hw);
   assign pos_next   = byte_position_ff + POS_W'(1);

   // the byte lands in the field its position falls in; past the second
   // field everything goes to the third
   always_comb begin
      type_acc_nx   = type_acc_ff;
      second_acc_nx = second_acc_ff;
      third_acc_nx  = third_acc_ff;
      if (total != '0) begin
         if (byte_position_ff < type_end) begin
            type_acc_nx = {type_acc_ff[TYPE_W-BYTE_W-1:0], req_data.data_byte};
         end else if (byte_position_ff < second_end) begin
            second_acc_nx = ACC_W'({second_acc_ff, req_data.data_byte});
         end else begin
            third_acc_nx = ACC_W'({third_acc_ff, req_data.data_byte});
         end
      end
   end

   // all-zero widths: every byte completes an entry on its own
   assign entry_done = (total == '0) || (pos_next >= total);
   assign etype      = (tw == '0) ? TYPE_IN_USE : type_acc_nx;
   assign gen_big    = (third_acc_nx >> GEN_BITS) != '0;

   always_comb begin
      byte_position_in  = byte_position_ff;
      type_acc_in       = type_acc_ff;
      second_acc_in     = second_acc_ff;
      third_acc_in      = third_acc_ff;
      current_object_in = current_object_ff;
      entries_left_in   = entries_left_ff;
      produce           = 1'b0;
      result            = '0;

      if (req_accept) begin
         if (req_data.operation == OP_HEADER) begin
            // new subsection, any partial entry is dropped
            current_object_in = req_data.first_object;
            entries_left_in   = req_data.entry_count;
            byte_position_in  = '0;
            type_acc_in       = '0;
            second_acc_in     = '0;
            third_acc_in      = '0;
         end else if (entries_left_ff == '0) begin
            // stray byte: report it, keep the state
            produce              = 1'b1;
            result.object_number = current_object_ff;
            result.status        = ST_OUTSIDE;
         end else if (!entry_done) begin
            byte_position_in = pos_next;
            type_acc_in      = type_acc_nx;
            second_acc_in    = second_acc_nx;
            third_acc_in     = third_acc_nx;
         end else begin
            produce                   = 1'b1;
            result.object_number      = current_object_ff;
            result.entry_type         = etype;
            result.second_value       = VALUE_W'(second_acc_nx);
            result.third_value        = VALUE_W'(third_acc_nx);
            result.last_in_subsection = (entries_left_ff == COUNT_W'(1));
            if (etype > TYPE_COMPRESSED) begin
               result.status = ST_BAD_TYPE;
            end else if (etype != TYPE_COMPRESSED && gen_big) begin
               result.status = ST_BIG_GEN;
            end else begin
               result.status = ST_OK;
            end
            current_object_in = current_object_ff + OBJECT_W'(1);
            entries_left_in   = entries_left_ff - COUNT_W'(1);
            byte_position_in  = '0;
            type_acc_in       = '0;
            second_acc_in     = '0;
            third_acc_in      = '0;
         end
      end
   end

   // output register with skid buffer behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (produce) begin
         if (!rsp_valid_ff || rsp_pop) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_width_ff     <= TYPE_WIDTH_RST;
         second_width_ff   <= SECOND_WIDTH_RST;
         third_width_ff    <= THIRD_WIDTH_RST;
         byte_position_ff  <= '0;
         type_acc_ff       <= '0;
         second_acc_ff     <= '0;
         third_acc_ff      <= '0;
         current_object_ff <= '0;
         entries_left_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TYPE_WIDTH:   type_width_ff   <= csr_data[TYPE_WIDTH_W-1:0];
               REG_SECOND_WIDTH: second_width_ff <= csr_data[FIELD_WIDTH_W-1:0];
               REG_THIRD_WIDTH:  third_width_ff  <= csr_data[FIELD_WIDTH_W-1:0];
               default: ;
            endcase
         end
         byte_position_ff  <= byte_position_in;
         type_acc_ff       <= type_acc_in;
         second_acc_ff     <= second_acc_in;
         third_acc_ff      <= third_acc_in;
         current_object_ff <= current_object_in;
         entries_left_ff   <= entries_left_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTHESIS
   // the skid buffer only fills behind a held response
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid buffer full with response register empty");

   // an entry always completes before the position reaches the widest total
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      byte_position_ff < POS_W'(TYPE_MAX_BYTES + 2 * MAX_FIELD_BYTES))
      else $error("byte position beyond largest entry");

   // a header restarts the entry
   a_header_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.operation == OP_HEADER |=> byte_position_ff == '0)
      else $error("header did not clear the entry position");

   // each decoded entry uses up one slot of the subsection
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      produce && result.status != ST_OUTSIDE |=>
         entries_left_ff == $past(entries_left_ff) - COUNT_W'(1))
      else $error("entry count did not step down on a decoded entry");
`endif

endmodule

// ----- verif/xref_stream_entry_decoder_test.sv -----
`timescale 1ns / 1ps

module xref_stream_entry_decoder_test;
   import xsed_pkg::*;

   // index with no register behind it, writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;
   // cycles without any handshake before the run is declared hung
   localparam int QUIET_LIMIT = 5000;
   localparam int SEGMENT_ITEMS = 50;

   typedef enum bit {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      req_type                  req;
      logic [CSR_INDEX_W-1:0]   csr_idx;
      logic [CSR_DATA_W-1:0]    csr_val;
      bit                       pinned;
      rsp_type                  want;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   // idling percentages, changed per phase by the stimulus process
   int send_gap_pct = 0;
   int stall_pct = 0;

   // a directed request may carry a hand-written expected entry
   bit      pin_valid = 1'b0;
   rsp_type pin_rsp = '0;

   int failures = 0;
   int quiet_cycles = 0;
   int reqs_sent = 0;

   rsp_type       entries_due[$];
   stim_row_type  directed_rows[$];

   // shadow of the decoder: widths and entry state
   logic [TYPE_WIDTH_W-1:0]  cfg_type_w;
   logic [FIELD_WIDTH_W-1:0] cfg_second_w;
   logic [FIELD_WIDTH_W-1:0] cfg_third_w;
   logic [POS_W-1:0]         byte_pos;
   logic [TYPE_W-1:0]        type_acc;
   logic [VALUE_W-1:0]       second_acc;
   logic [VALUE_W-1:0]       third_acc;
   logic [OBJECT_W-1:0]      obj_cursor;
   logic [COUNT_W-1:0]       entries_remaining;

   xref_stream_entry_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // widths as the decoder uses them, oversized values saturate
   function automatic int unsigned type_bytes();
      return (cfg_type_w > TYPE_MAX_BYTES) ? TYPE_MAX_BYTES : cfg_type_w;
   endfunction

   function automatic int unsigned second_bytes();
      return (cfg_second_w > MAX_FIELD_BYTES_DEF) ? MAX_FIELD_BYTES_DEF : cfg_second_w;
   endfunction

   function automatic int unsigned third_bytes();
      return (cfg_third_w > MAX_FIELD_BYTES_DEF) ? MAX_FIELD_BYTES_DEF : cfg_third_w;
   endfunction

   function automatic void drop_partial_entry();
      byte_pos   = '0;
      type_acc   = '0;
      second_acc = '0;
      third_acc  = '0;
   endfunction

   // steps the shadow by one accepted request, returns 1 when an entry is due
   function automatic bit decode_request(input req_type r, output rsp_type e);
      int unsigned tw, sw, hw, total;
      logic [TYPE_W-1:0] etype;
      e = '0;
      if (r.operation == OP_HEADER) begin
         obj_cursor = r.first_object;
         entries_remaining = r.entry_count;
         drop_partial_entry();
         return 1'b0;
      end
      // stray byte: reported against the current object, nothing else moves
      if (entries_remaining == '0) begin
         e.object_number = obj_cursor;
         e.status = ST_OUTSIDE;
         return 1'b1;
      end
      tw = type_bytes();
      sw = second_bytes();
      hw = third_bytes();
      total = tw + sw + hw;
      if (total != 0) begin
         if (byte_pos < tw)
            type_acc = {type_acc[TYPE_W-BYTE_W-1:0], r.data_byte};
         else if (byte_pos < tw + sw)
            second_acc = {second_acc[VALUE_W-BYTE_W-1:0], r.data_byte};
         else
            third_acc = {third_acc[VALUE_W-BYTE_W-1:0], r.data_byte};
         byte_pos = byte_pos + 1'b1;
         if (byte_pos < total)
            return 1'b0;
      end
      // zero-width type field means in use
      etype = (tw == 0) ? TYPE_IN_USE : type_acc;
      e.object_number = obj_cursor;
      e.entry_type = etype;
      e.second_value = second_acc;
      e.third_value = third_acc;
      e.last_in_subsection = (entries_remaining == 1);
      if (etype > TYPE_COMPRESSED)
         e.status = ST_BAD_TYPE;
      else if (etype != TYPE_COMPRESSED && (third_acc >> GEN_BITS) != '0)
         e.status = ST_BIG_GEN;
      else
         e.status = ST_OK;
      obj_cursor = obj_cursor + 1'b1;
      entries_remaining = entries_remaining - 1'b1;
      drop_partial_entry();
      return 1'b1;
   endfunction

   function automatic void compare_entry(input rsp_type want, input rsp_type got);
      if (got.object_number !== want.object_number) begin
         $error("object_number expected %h got %h", want.object_number, got.object_number);
         failures++;
      end
      if (got.entry_type !== want.entry_type) begin
         $error("entry_type expected %h got %h", want.entry_type, got.entry_type);
         failures++;
      end
      if (got.second_value !== want.second_value) begin
         $error("second_value expected %h got %h", want.second_value, got.second_value);
         failures++;
      end
      if (got.third_value !== want.third_value) begin
         $error("third_value expected %h got %h", want.third_value, got.third_value);
         failures++;
      end
      if (got.last_in_subsection !== want.last_in_subsection) begin
         $error("last_in_subsection expected %b got %b",
                want.last_in_subsection, got.last_in_subsection);
         failures++;
      end
      if (got.status !== want.status) begin
         $error("status expected %0d got %0d", want.status, got.status);
         failures++;
      end
   endfunction

   // checker: responses first, since an entry can never leave on the edge
   // its last byte goes in
   always @(posedge clock) begin : watch
      rsp_type oldest;
      rsp_type predicted;
      bit      produces;
      if (reset) begin
         cfg_type_w = TYPE_WIDTH_RST;
         cfg_second_w = SECOND_WIDTH_RST;
         cfg_third_w = THIRD_WIDTH_RST;
         drop_partial_entry();
         obj_cursor = '0;
         entries_remaining = '0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (entries_due.size() == 0) begin
               $error("entry returned with none outstanding, object_number %h",
                      rsp_data.object_number);
               failures++;
            end else begin
               oldest = entries_due.pop_front();
               compare_entry(oldest, rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            produces = decode_request(req_data, predicted);
            // hand-written expectation wins, the shadow still advances
            if (pin_valid) begin
               predicted = pin_rsp;
               produces = 1'b1;
            end
            if (produces)
               entries_due.push_back(predicted);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TYPE_WIDTH:   cfg_type_w = csr_data[TYPE_WIDTH_W-1:0];
               REG_SECOND_WIDTH: cfg_second_w = csr_data;
               REG_THIRD_WIDTH:  cfg_third_w = csr_data;
               default: ;
            endcase
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("xref_stream_entry_decoder_test: FAIL");
            $finish;
         end
      end
   end

   // one request, with random gaps ahead of it; returns on the accepting edge
   task automatic push_req(input req_type r, input bit pinned, input rsp_type want);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      pin_valid = pinned;
      pin_rsp = want;
      do @(posedge clock); while (req_stall);
      reqs_sent++;
   endtask

   // let every outstanding entry drain, plus the pipeline depth
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      pin_valid = 1'b0;
      while (entries_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // header fields random in body requests and vice versa, so every bit moves
   function automatic req_type header_req(input logic [OBJECT_W-1:0] first,
                                          input logic [COUNT_W-1:0] count);
      req_type r;
      r.operation = OP_HEADER;
      r.first_object = first;
      r.entry_count = count;
      r.data_byte = BYTE_W'($urandom);
      return r;
   endfunction

   function automatic req_type byte_req(input logic [BYTE_W-1:0] b);
      req_type r;
      r.operation = OP_BODY;
      r.first_object = $urandom;
      r.entry_count = $urandom;
      r.data_byte = b;
      return r;
   endfunction

   function automatic rsp_type entry(input logic [OBJECT_W-1:0] obj,
                                     input logic [TYPE_W-1:0] etype,
                                     input logic [VALUE_W-1:0] second,
                                     input logic [VALUE_W-1:0] third,
                                     input logic last,
                                     input logic [STATUS_W-1:0] st);
      return '{obj, etype, second, third, last, st};
   endfunction

   function automatic stim_row_type hdr_row(input logic [OBJECT_W-1:0] first,
                                            input logic [COUNT_W-1:0] count);
      return '{ROW_REQ, header_req(first, count), '0, '0, 1'b0, '0};
   endfunction

   function automatic stim_row_type byte_row(input logic [BYTE_W-1:0] b);
      return '{ROW_REQ, byte_req(b), '0, '0, 1'b0, '0};
   endfunction

   function automatic stim_row_type pinned_row(input logic [BYTE_W-1:0] b,
                                               input rsp_type want);
      return '{ROW_REQ, byte_req(b), '0, '0, 1'b1, want};
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      return '{ROW_CSR, '0, idx, val, 1'b0, '0};
   endfunction

   // body byte biased towards sensible entries: known types, mostly
   // small generations, with the odd wild value
   function automatic logic [BYTE_W-1:0] field_byte(input int unsigned pos);
      int unsigned tw, sw, hw;
      tw = type_bytes();
      sw = second_bytes();
      hw = third_bytes();
      if (pos < tw) begin
         if (pos == tw - 1)
            return ($urandom_range(7) != 0) ? BYTE_W'($urandom_range(2)) : BYTE_W'($urandom);
         return ($urandom_range(7) != 0) ? '0 : BYTE_W'($urandom);
      end
      if (pos < tw + sw || pos + 2 >= tw + sw + hw)
         return BYTE_W'($urandom);
      return ($urandom_range(3) != 0) ? '0 : BYTE_W'($urandom);
   endfunction

   // mostly whole subsections, some cut short, some stray bytes and
   // headers with wild counts; a subsection stops where the budget runs out
   task automatic run_random(input int n);
      int stop_at, pick, count, per_entry, total, cut;
      logic [OBJECT_W-1:0] first;
      stop_at = reqs_sent + n;
      while (reqs_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            count = $urandom_range(1, 6);
            first = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom;
            push_req(header_req(first, count), 1'b0, '0);
            per_entry = type_bytes() + second_bytes() + third_bytes();
            if (per_entry == 0)
               per_entry = 1;
            total = count * per_entry;
            cut = ($urandom_range(9) == 0) ? $urandom_range(total - 1) : total;
            for (int k = 0; k < cut && reqs_sent < stop_at; k++)
               push_req(byte_req(field_byte(k % per_entry)), 1'b0, '0);
         end else if (pick < 88) begin
            push_req(byte_req(BYTE_W'($urandom)), 1'b0, '0);
         end else begin
            push_req(header_req($urandom, $urandom), 1'b0, '0);
            repeat ($urandom_range(10)) push_req(byte_req(BYTE_W'($urandom)), 1'b0, '0);
         end
      end
   endtask

   initial begin : stimulus
      // width settings per segment: reset values, all zero, widest,
      // oversized, then odd mixes; later segments draw at random
      int set_type[8]   = '{1, 0, 4, 7, 0, 2, 3, 5};
      int set_second[8] = '{4, 0, 8, 15, 2, 3, 1, 9};
      int set_third[8]  = '{2, 0, 8, 15, 1, 0, 6, 12};
      int seg, tw, sw, hw;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // byte before any header, then all-zero widths across the
      // object number wrap, then a stray byte after the subsection ends
      directed_rows.push_back(pinned_row(8'h5A, entry('0, '0, '0, '0, 1'b0, ST_OUTSIDE)));
      directed_rows.push_back(csr_row(REG_TYPE_WIDTH, 4'd0));
      directed_rows.push_back(csr_row(REG_SECOND_WIDTH, 4'd0));
      directed_rows.push_back(csr_row(REG_THIRD_WIDTH, 4'd0));
      directed_rows.push_back(hdr_row(32'hFFFF_FFFF, 32'd2));
      directed_rows.push_back(pinned_row(8'hFF,
         entry(32'hFFFF_FFFF, TYPE_IN_USE, '0, '0, 1'b0, ST_OK)));
      directed_rows.push_back(pinned_row(8'h00, entry('0, TYPE_IN_USE, '0, '0, 1'b1, ST_OK)));
      directed_rows.push_back(pinned_row(8'h33, entry(32'd1, '0, '0, '0, 1'b0, ST_OUTSIDE)));
      // one type byte, one second byte, three third bytes
      directed_rows.push_back(csr_row(REG_TYPE_WIDTH, 4'd1));
      directed_rows.push_back(csr_row(REG_SECOND_WIDTH, 4'd1));
      directed_rows.push_back(csr_row(REG_THIRD_WIDTH, 4'd3));
      directed_rows.push_back(hdr_row('0, 32'hFFFF_FFFF));
      // unknown type
      directed_rows.push_back(byte_row(8'h03));
      directed_rows.push_back(byte_row(8'h80));
      directed_rows.push_back(byte_row(8'h00));
      directed_rows.push_back(byte_row(8'h00));
      directed_rows.push_back(pinned_row(8'h01,
         entry('0, 32'd3, 64'h80, 64'h1, 1'b0, ST_BAD_TYPE)));
      // generation just past 16 bits on an in-use entry
      directed_rows.push_back(byte_row(8'h01));
      directed_rows.push_back(byte_row(8'hFF));
      directed_rows.push_back(byte_row(8'h01));
      directed_rows.push_back(byte_row(8'h00));
      directed_rows.push_back(pinned_row(8'h00,
         entry(32'd1, TYPE_IN_USE, 64'hFF, 64'h1_0000, 1'b0, ST_BIG_GEN)));
      // second field removed halfway through an entry
      directed_rows.push_back(byte_row(8'h02));
      directed_rows.push_back(byte_row(8'h7F));
      directed_rows.push_back(csr_row(REG_SECOND_WIDTH, 4'd0));
      directed_rows.push_back(byte_row(8'hAA));
      directed_rows.push_back(byte_row(8'hBB));
      // header landing inside an entry throws the partial entry away
      directed_rows.push_back(hdr_row(32'd5, 32'd1));
      directed_rows.push_back(byte_row(8'h01));
      directed_rows.push_back(hdr_row(32'd9, 32'd1));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_reg(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         else
            push_req(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].want);
      end

      write_reg(REG_SPARE, CSR_DATA_W'($urandom));

      // three idling regimes, five width settings each
      for (seg = 0; seg < 15; seg++) begin
         case (seg / 5)
            0: begin
               send_gap_pct = 9;
               stall_pct = 87;
            end
            1: begin
               send_gap_pct = 87;
               stall_pct = 9;
            end
            default: begin
               send_gap_pct = 0;
               stall_pct = 0;
            end
         endcase
         if (seg < 8) begin
            tw = set_type[seg];
            sw = set_second[seg];
            hw = set_third[seg];
         end else begin
            tw = $urandom_range(7);
            sw = $urandom_range(15);
            hw = $urandom_range(15);
         end
         // top data bit is unused by the type width register but still toggled
         write_reg(REG_TYPE_WIDTH, {1'($urandom_range(1)), 3'(tw)});
         write_reg(REG_SECOND_WIDTH, 4'(sw));
         write_reg(REG_THIRD_WIDTH, 4'(hw));
         run_random(SEGMENT_ITEMS);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("xref_stream_entry_decoder_test: PASS");
      else
         $display("xref_stream_entry_decoder_test: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/xsed_pkg.sv
rtl/xref_stream_entry_decoder.sv
verif/xref_stream_entry_decoder_test.sv
